/* design/dfs_pkg.sv */
// Shared types, constants and the fold table for the diacritic fold stream.
package dfs_pkg;

  localparam logic [7:0] CR_BYTE   = 8'd13;
  localparam logic [7:0] ALA_FIRST = 8'd161;

  localparam logic [1:0] REG_PASS_ALL = 2'd0;
  localparam logic [1:0] REG_MAP_OFF  = 2'd1;
  localparam logic [1:0] REG_DROP_CR  = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic pass_all;
    logic map_off;
    logic drop_cr;
  } cfg_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       has_char;
    logic       two;
    logic       word_end;
  } job_t;

  // {first, second}; zero first byte means pass unchanged
  function automatic logic [15:0] fold_entry(input logic [7:0] ch);
    logic [15:0] e;
    e = 16'd0;
    case (ch) inside
      8'd161:            e = {"L", 8'd0};
      8'd162:            e = {"O", 8'd0};
      8'd163:            e = {"D", 8'd0};
      8'd164:            e = {"T", "h"};
      8'd165:            e = {"A", "E"};
      8'd166:            e = {"O", "E"};
      [8'd167:8'd171]:   e = {"_", 8'd0};
      8'd172:            e = {"O", 8'd0};
      8'd173:            e = {"U", 8'd0};
      [8'd174:8'd176]:   e = {"_", 8'd0};
      8'd177:            e = {"l", 8'd0};
      8'd178:            e = {"o", 8'd0};
      8'd179:            e = {"d", 8'd0};
      8'd180:            e = {"t", "h"};
      8'd181:            e = {"a", "e"};
      8'd182:            e = {"o", "e"};
      8'd183:            e = {"_", 8'd0};
      8'd184:            e = {"i", 8'd0};
      8'd185:            e = {"_", 8'd0};
      8'd186:            e = {"d", 8'd0};
      8'd187:            e = {"_", 8'd0};
      8'd188:            e = {"o", 8'd0};
      8'd189:            e = {"u", 8'd0};
      [8'd192:8'd197]:   e = {"A", 8'd0};
      8'd198:            e = {"A", "E"};
      8'd199:            e = {"C", 8'd0};
      [8'd200:8'd203]:   e = {"E", 8'd0};
      [8'd204:8'd207]:   e = {"I", 8'd0};
      8'd208:            e = {"T", "h"};
      8'd209:            e = {"N", 8'd0};
      [8'd210:8'd214]:   e = {"O", 8'd0};
      8'd215:            e = {" ", 8'd0};
      8'd216:            e = {"O", 8'd0};
      [8'd217:8'd220]:   e = {"U", 8'd0};
      8'd221:            e = {"Y", 8'd0};
      8'd222:            e = {"T", "h"};
      8'd223:            e = {"s", "s"};
      [8'd224:8'd229]:   e = {"a", 8'd0};
      8'd230:            e = {"a", "e"};
      8'd231:            e = {"c", 8'd0};
      [8'd232:8'd235]:   e = {"e", 8'd0};
      [8'd236:8'd239]:   e = {"i", 8'd0};
      8'd240:            e = {"t", "h"};
      8'd241:            e = {"n", 8'd0};
      [8'd242:8'd246]:   e = {"o", 8'd0};
      8'd247:            e = {" ", 8'd0};
      8'd248:            e = {"o", 8'd0};
      [8'd249:8'd252]:   e = {"u", 8'd0};
      8'd253:            e = {"Y", 8'd0};
      8'd254:            e = {"t", "h"};
      8'd255:            e = {"Y", 8'd0};
      default:           e = 16'd0;
    endcase
    return e;
  endfunction

endpackage

/* design/dfs_front.sv */
// Front end: accepts input words, classifies and folds them into queue jobs.
module dfs_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char,
  input  logic          in_word_end,
  input  dfs_pkg::cfg_t cfg,
  input  logic          q_ready,
  output logic          push,
  output dfs_pkg::job_t push_job
);

  logic [15:0] entry;
  logic        drop;

  assign entry    = dfs_pkg::fold_entry(in_char);
  assign in_ready = q_ready;

  always_comb begin
    push_job.first    = in_char;
    push_job.second   = 8'd0;
    push_job.has_char = 1'b1;
    push_job.two      = 1'b0;
    push_job.word_end = in_word_end;
    drop              = 1'b0;
    if (cfg.pass_all) begin
      push_job.first = in_char;
    end else if (in_char == dfs_pkg::CR_BYTE && cfg.drop_cr) begin
      // drop a CR inside a word, keep an empty marker when it ends one
      drop              = !in_word_end;
      push_job.first    = 8'd0;
      push_job.has_char = 1'b0;
      push_job.word_end = 1'b1;
    end else if (!cfg.map_off && in_char >= dfs_pkg::ALA_FIRST && entry[15:8] != 8'd0) begin
      push_job.first  = entry[15:8];
      push_job.second = entry[7:0];
      push_job.two    = entry[7:0] != 8'd0;
    end
  end

  assign push = in_valid && q_ready && !drop;

endmodule

/* design/dfs_queue.sv */
// Short job queue between front and back ends.
module dfs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dfs_pkg::job_t push_job,
  output logic          q_ready,
  input  logic          pop,
  output logic          q_valid,
  output dfs_pkg::job_t head_job
);

  dfs_pkg::job_t                mem_r [dfs_pkg::QUEUE_DEPTH];
  logic [dfs_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dfs_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dfs_pkg::QPTR_W:0]     count_r, count_nxt;

  assign q_ready  = count_r != (dfs_pkg::QPTR_W+1)'(dfs_pkg::QUEUE_DEPTH);
  assign q_valid  = count_r != '0;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/dfs_back.sv */
// Back end: drains queue jobs into output words, splitting expansions in two.
module dfs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  dfs_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_has_char,
  output logic          out_run_last,
  output logic          out_word_last
);

  logic       valid_r, valid_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] sec_r;
  logic       sec_we_r;
  logic [7:0] char_r;
  logic       has_r, run_r, wlast_r;
  logic       load;

  assign load = !valid_r || out_ready;
  assign pop  = load && !pend_r && q_valid;

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    if (load) begin
      if (pend_r) begin
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end else begin
        valid_nxt = q_valid;
        pend_nxt  = q_valid && head_job.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        char_r  <= sec_r;
        has_r   <= 1'b1;
        run_r   <= 1'b1;
        wlast_r <= sec_we_r;
      end else begin
        char_r  <= head_job.first;
        has_r   <= head_job.has_char;
        run_r   <= !head_job.two;
        wlast_r <= head_job.word_end && !head_job.two;
      end
    end
    if (pop) begin
      sec_r    <= head_job.second;
      sec_we_r <= head_job.word_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_char      = char_r;
  assign out_has_char  = has_r;
  assign out_run_last  = run_r;
  assign out_word_last = wlast_r;

endmodule

/* design/diacritic_fold_stream.sv */
// Top level of the diacritic fold stream: config registers, front, queue and back.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | in_char, in_word_end
//   out_    | output    | out_valid / out_ready | out_char, out_has_char, out_run_last,
//           |           |                       | out_word_last
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input word per cycle while the queue is not full; a folded expansion occupies the output for two words.
// An accepted word is registered in the queue and then in the output register before out_valid rises.
// The four-entry queue absorbs output stalls; in_ready drops only when it is full.
// Reset empties the queue and output and loads the register defaults; cfg is always ready.
module diacritic_fold_stream (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_word_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_has_char,
  output logic       out_run_last,
  output logic       out_word_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  dfs_pkg::cfg_t cfg_r, cfg_nxt;
  dfs_pkg::job_t push_job, head_job;
  logic          push, pop, q_ready, q_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        dfs_pkg::REG_PASS_ALL: cfg_nxt.pass_all = cfg_data;
        dfs_pkg::REG_MAP_OFF:  cfg_nxt.map_off  = cfg_data;
        dfs_pkg::REG_DROP_CR:  cfg_nxt.drop_cr  = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pass_all: 1'b0, map_off: 1'b0, drop_cr: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dfs_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .in_word_end (in_word_end),
    .cfg         (cfg_r),
    .q_ready     (q_ready),
    .push        (push),
    .push_job    (push_job)
  );

  dfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  dfs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_has_char  (out_has_char),
    .out_run_last  (out_run_last),
    .out_word_last (out_word_last)
  );

endmodule
